// File: src/atm_pkg.sv
package atm_pkg;

  localparam int NUM_STAGES = 39;

  localparam int Q_W   = 23;
  localparam int NUM_W = 47;
  localparam int DEN_W = 30;
  localparam int QUO_W = 20;
  localparam int ROOT_W = 8;

  localparam logic [22:0] Q_MAX      = 23'h7FFFFF;
  localparam logic [31:0] SCALE_SAT  = 32'd67107840;
  localparam logic [25:0] OFFSET_Q18 = 26'd262;
  localparam logic [23:0] FIT_C1     = 24'd6443;
  localparam logic [46:0] FIT_C2     = 47'd6221655;
  localparam logic [17:0] FIT_C3     = 18'd257879;
  localparam logic [23:0] FIT_C4     = 24'd113496;
  localparam logic [47:0] FIT_C5     = 48'd16360801741;
  localparam logic [15:0] OUT_SCALE  = 16'd65025;

  typedef logic [17:0] coef_in_t;
  typedef logic signed [19:0] coef_out_t;

  localparam coef_in_t MAT_IN [3][3] = '{
    '{18'd156550, 18'd92951,  18'd12643},
    '{18'd19923,  18'd238116, 18'd4105},
    '{18'd7445,   18'd35083,  18'd219616}
  };

  localparam coef_out_t MAT_OUT [3][3] = '{
    '{20'sd420676, -20'sd139219, -20'sd19312},
    '{-20'sd26760, 20'sd290490,  -20'sd1586},
    '{-20'sd857,   -20'sd19074,  20'sd282072}
  };

endpackage

// File: src/aces_tone_map_pixel.sv
// throughput: one pixel per clock, start may stay high every cycle
// busy never rises and results are shown for one cycle, the receiver cannot stall
// latency set mostly by the 20-stage divider of the fit and the 8-stage square root
// reset clears the valid pipeline and sets exposure_gain to 1.0 (256)
module aces_tone_map_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        strobe_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);
  import atm_pkg::*;

  logic [15:0] exp_q;
  logic [NUM_STAGES-1:0] vld_q;

  logic [15:0] pix [3];
  logic [31:0] p_d [3], p_q [3];
  logic [22:0] x_d [3], x_q [3];
  logic [40:0] mi_d [3][3], mi_q [3][3];
  logic [22:0] v_d [3], v_q [3];
  logic [40:0] tp_d [3], tp_q [3];
  logic [22:0] v5_q [3];
  logic [46:0] bp_d [3], bp_q [3], ap_d [3], ap_q [3];
  logic [46:0] num_d [3], num_q [3];
  logic [29:0] den_d [3], den_q [3];
  logic        neg_d [3], neg_q [3];
  logic [19:0] quo [3];
  logic        quo_neg [3];
  logic signed [41:0] mo_d [3][3], mo_q [3][3];
  logic [22:0] y_d [3], y_q [3];
  logic [38:0] m_d [3], m_q [3];
  logic [15:0] z_d [3], z_q [3];
  logic        zs_d [3], zs_q [3];
  logic [7:0]  root [3];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign pix[0] = red_in_i;
  assign pix[1] = green_in_i;
  assign pix[2] = blue_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 16'd256;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        exp_q <= cfg_data_i;
      end
      vld_q <= {vld_q[NUM_STAGES-2:0], start && !busy};
    end
  end

  // exposure scale, input matrix, fit numerator and denominator
  always_comb begin
    logic [38:0] sh;
    logic [23:0] fold1;
    logic [16:0] fold2;
    logic [22:0] hi;
    logic [7:0]  h2;
    logic [42:0] sum;
    logic [25:0] vs;
    logic [23:0] t;
    logic [47:0] bs;
    for (int c = 0; c < 3; c++) begin
      p_d[c] = 32'(exp_q) * 32'(pix[c]);

      sh    = {p_q[c][25:0], 13'b0};
      hi    = sh[38:16];
      fold1 = 24'(hi) + 24'(sh[15:0]);
      h2    = fold1[23:16];
      fold2 = 17'(h2) + 17'(fold1[15:0]);
      x_d[c] = (p_q[c] >= SCALE_SAT) ? Q_MAX
             : hi + 23'(h2) + 23'(fold2 >= 17'd65535);

      for (int k = 0; k < 3; k++) begin
        mi_d[c][k] = 41'(MAT_IN[c][k]) * 41'(x_q[k]);
      end
      sum = 43'(mi_q[c][0]) + 43'(mi_q[c][1]) + 43'(mi_q[c][2]);
      vs  = 26'(sum[42:18]) + OFFSET_Q18;
      v_d[c] = (vs > 26'(Q_MAX)) ? Q_MAX : vs[22:0];

      tp_d[c] = 41'(FIT_C3) * 41'(v_q[c]);

      t = 24'(tp_q[c][40:18]) + FIT_C4;
      bp_d[c] = 47'(v5_q[c]) * 47'(t);
      ap_d[c] = 47'(v5_q[c]) * 47'(24'(v5_q[c]) + FIT_C1);

      bs = 48'(bp_q[c]) + FIT_C5;
      den_d[c] = bs[47:18];
      neg_d[c] = ap_q[c] < FIT_C2;
      num_d[c] = neg_d[c] ? (FIT_C2 - ap_q[c]) : (ap_q[c] - FIT_C2);
    end
  end

  // output matrix, clamp, scale for the root
  always_comb begin
    logic signed [20:0] rv [3];
    logic signed [43:0] acc;
    logic signed [43:0] ash;
    logic [38:0]        zw;
    for (int c = 0; c < 3; c++) begin
      rv[c] = quo_neg[c] ? -$signed({1'b0, quo[c]}) : $signed({1'b0, quo[c]});
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        mo_d[c][k] = 42'(MAT_OUT[c][k]) * 42'(rv[k]);
      end
      acc = 44'(mo_q[c][0]) + 44'(mo_q[c][1]) + 44'(mo_q[c][2]);
      ash = acc >>> 18;
      if (ash < 0) begin
        y_d[c] = '0;
      end else if (ash > 44'(Q_MAX)) begin
        y_d[c] = Q_MAX;
      end else begin
        y_d[c] = ash[22:0];
      end

      m_d[c] = 39'(OUT_SCALE) * 39'(y_q[c]);

      zw = m_q[c] >> 18;
      zs_d[c] = |zw[20:16];
      z_d[c]  = zw[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      p_q[c]   <= p_d[c];
      x_q[c]   <= x_d[c];
      for (int k = 0; k < 3; k++) begin
        mi_q[c][k] <= mi_d[c][k];
        mo_q[c][k] <= mo_d[c][k];
      end
      v_q[c]   <= v_d[c];
      tp_q[c]  <= tp_d[c];
      v5_q[c]  <= v_q[c];
      bp_q[c]  <= bp_d[c];
      ap_q[c]  <= ap_d[c];
      num_q[c] <= num_d[c];
      den_q[c] <= den_d[c];
      neg_q[c] <= neg_d[c];
      y_q[c]   <= y_d[c];
      m_q[c]   <= m_d[c];
      z_q[c]   <= z_d[c];
      zs_q[c]  <= zs_d[c];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    atm_div u_div (
      .clk_i (clk_i),
      .num_i (num_q[c]),
      .den_i (den_q[c]),
      .neg_i (neg_q[c]),
      .quo_o (quo[c]),
      .neg_o (quo_neg[c])
    );

    atm_isqrt u_isqrt (
      .clk_i  (clk_i),
      .val_i  (z_q[c]),
      .sat_i  (zs_q[c]),
      .root_o (root[c])
    );
  end

  assign strobe_o    = vld_q[NUM_STAGES-1];
  assign red_out_o   = root[0];
  assign green_out_o = root[1];
  assign blue_out_o  = root[2];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(NUM_STAGES) strobe_o)
    else $error("result strobe missing after pipeline latency");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && red_in_i == '0 && green_in_i == '0 && blue_in_i == '0
    |-> ##(NUM_STAGES) (red_out_o == '0 && green_out_o == '0 && blue_out_o == '0))
    else $error("black pixel did not map to black");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (50'(num_q[0]) < (50'(den_q[0]) << QUO_W)
               && 50'(num_q[1]) < (50'(den_q[1]) << QUO_W)
               && 50'(num_q[2]) < (50'(den_q[2]) << QUO_W)))
    else $error("fit quotient exceeds divider width");

endmodule

// File: src/atm_div.sv
module atm_div (
  input  logic        clk_i,
  input  logic [46:0] num_i,
  input  logic [29:0] den_i,
  input  logic        neg_i,
  output logic [19:0] quo_o,
  output logic        neg_o
);
  import atm_pkg::*;

  localparam int TrialW = NUM_W + 3;

  logic [NUM_W-1:0] rem_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic             neg_in [QUO_W];

  logic [NUM_W-1:0] rem_d [QUO_W];
  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             neg_q [QUO_W];

  // one quotient bit per stage, msb first
  always_comb begin
    logic [TrialW-1:0] trial;
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    neg_in[0] = neg_i;
    for (int j = 1; j < QUO_W; j++) begin
      rem_in[j] = rem_q[j-1];
      den_in[j] = den_q[j-1];
      quo_in[j] = quo_q[j-1];
      neg_in[j] = neg_q[j-1];
    end
    for (int j = 0; j < QUO_W; j++) begin
      trial = TrialW'(den_in[j]) << (QUO_W - 1 - j);
      if (TrialW'(rem_in[j]) >= trial) begin
        rem_d[j] = rem_in[j] - trial[NUM_W-1:0];
        quo_d[j] = quo_in[j] | (QUO_W'(1) << (QUO_W - 1 - j));
      end else begin
        rem_d[j] = rem_in[j];
        quo_d[j] = quo_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QUO_W; j++) begin
      rem_q[j] <= rem_d[j];
      den_q[j] <= den_in[j];
      quo_q[j] <= quo_d[j];
      neg_q[j] <= neg_in[j];
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign neg_o = neg_q[QUO_W-1];

endmodule

// File: src/atm_isqrt.sv
module atm_isqrt (
  input  logic        clk_i,
  input  logic [15:0] val_i,
  input  logic        sat_i,
  output logic [7:0]  root_o
);
  import atm_pkg::*;

  logic [15:0]       val_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic              sat_in  [ROOT_W];

  logic [15:0]       val_q  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic              sat_q  [ROOT_W];

  // one root bit per stage, msb first
  always_comb begin
    logic [ROOT_W-1:0] cand;
    logic [15:0]       sq;
    val_in[0]  = val_i;
    root_in[0] = '0;
    sat_in[0]  = sat_i;
    for (int j = 1; j < ROOT_W; j++) begin
      val_in[j]  = val_q[j-1];
      root_in[j] = root_q[j-1];
      sat_in[j]  = sat_q[j-1];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      cand = root_in[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
      sq   = 16'(cand) * 16'(cand);
      root_d[j] = (sq <= val_in[j]) ? cand : root_in[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ROOT_W; j++) begin
      val_q[j]  <= val_in[j];
      root_q[j] <= root_d[j];
      sat_q[j]  <= sat_in[j];
    end
  end

  assign root_o = sat_q[ROOT_W-1] ? '1 : root_q[ROOT_W-1];

endmodule

// File: bench/atm_pixel_checker.sv
module atm_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        strobe_i,
  input  logic [7:0]  red_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  blue_out_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QHI = 8388607;
  localparam longint QLO = -8388608;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb8_t;

  localparam longint M_IN [3][3] = '{
    '{156550, 92951, 12643}, '{19923, 238116, 4105}, '{7445, 35083, 219616}};
  localparam longint M_OUT [3][3] = '{
    '{420676, -139219, -19312}, '{-26760, 290490, -1586}, '{-857, -19074, 282072}};

  logic [15:0] gain_q;
  rgb8_t       tone_q[$];

  function automatic longint clamp_q18(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint filmic_fit(longint v);
    longint t, b, a36;
    t = ((257879 * v) >>> 18) + 113496;
    b = (v * t + 64'sd16360801741) >>> 18;
    a36 = v * (v + 6443) - 6221655;
    if (b < 1) b = 1;
    return clamp_q18(a36 / b);
  endfunction

  function automatic rgb8_t tone_map(logic [15:0] gain, logic [15:0] r, logic [15:0] g,
                                     logic [15:0] b);
    longint unsigned s;
    longint lin[3], ap[3], crv[3], acc;
    longint unsigned n[3];
    logic [15:0] chan[3];
    chan[0] = r; chan[1] = g; chan[2] = b;
    for (int i = 0; i < 3; i++) begin
      s = (longint'(gain) * longint'(chan[i]) * 8192) / 65535;
      lin[i] = (s > QHI) ? QHI : longint'(s);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += M_IN[i][k] * lin[k];
      ap[i] = clamp_q18((acc >>> 18) + 262);
    end
    for (int i = 0; i < 3; i++) crv[i] = filmic_fit(ap[i]);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += M_OUT[i][k] * crv[k];
      acc = clamp_q18(acc >>> 18);
      if (acc < 0) acc = 0;
      n[i] = int_sqrt(65025 * longint'(acc)) >> 9;
      if (n[i] > 255) n[i] = 255;
    end
    return '{red: n[0][7:0], green: n[1][7:0], blue: n[2][7:0]};
  endfunction

  assign pending_o = tone_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rgb8_t want;
    if (!rst_ni) begin
      gain_q <= 16'd256;
      fail_cnt_o <= 0;
      checked_o <= 0;
      tone_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) gain_q <= cfg_data_i;
      if (start_i && !busy_i) tone_q.push_back(tone_map(gain_q, red_in_i, green_in_i, blue_in_i));
      if (strobe_i) begin
        checked_o <= checked_o + 1;
        if (tone_q.size() == 0) begin
          $display("%t unexpected result r=%0d g=%0d b=%0d", $time, red_out_i, green_out_i,
                   blue_out_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = tone_q.pop_front();
          if (want.red !== red_out_i || want.green !== green_out_i ||
              want.blue !== blue_out_i) begin
            $display("%t mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d", $time,
                     want.red, want.green, want.blue, red_out_i, green_out_i, blue_out_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: bench/aces_tone_map_pixel_tb.sv
module aces_tone_map_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        strobe_o;
  logic [7:0]  red_out_o, green_out_o, blue_out_o;
  int          fail_cnt, pending, checked, pixels_sent;
  bit          gaps_on;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  aces_tone_map_pixel u_dut (.*);

  atm_pixel_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .red_in_i, .green_in_i, .blue_in_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i, .strobe_i(strobe_o),
    .red_out_i(red_out_o), .green_out_i(green_out_o), .blue_out_i(blue_out_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic set_exposure(logic [15:0] gain);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] gains[8];
    gains = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd32, 16'd2048, 16'd700, 16'($urandom)};
    gaps_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels at reset exposure
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'h0000, 16'h2000, 16'h0000);
    send_pixel(16'h0001, 16'h0001, 16'h0001);
    send_pixel(16'h8000, 16'h4000, 16'h1000);
    drain();
    set_exposure(16'hFFFF);
    // huge exposure saturates the brighter scaled channels, small ones stay in range
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0100, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0040);
    send_pixel(16'h5555, 16'hAAAA, 16'h0000);
    drain();
    set_exposure(16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h1234, 16'h0000, 16'hFFFF);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_exposure(gains[p]);
      gaps_on = (p != 3);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_pixel(rand_sample(), rand_sample(), rand_sample());
      end
      drain();
    end
    repeat (50) @(posedge clk_i);

    $display("sent %0d pixels over 11 exposure settings, %0d results checked",
             pixels_sent, checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule
